// ===== src/assert_macros.svh =====
// assertion macros for the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define RCLH_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: implication check failed");

// next-cycle implication, disabled while in reset
`define RCLH_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

// next-cycle implication that also holds across reset
`define RCLH_ASSERT_NXT_ALL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

// ===== src/rclh_pkg.sv =====
// shared types, constants and helpers for the run length hint block
// no dependencies

package rclh_pkg;

  localparam int MAX_ROWS   = 32;
  localparam int MAX_COLS   = 32;
  localparam int POS_W      = 5;
  localparam int RUN_W      = 6;
  localparam int CFG_AW     = 2;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;

  localparam logic [RUN_W-1:0] RUN_MAX = 6'd63;

  localparam logic [CFG_AW-1:0] REG_NUM_ROWS = 2'd0;
  localparam logic [CFG_AW-1:0] REG_NUM_COLS = 2'd1;

  localparam logic KIND_ROW = 1'b0;
  localparam logic KIND_COL = 1'b1;

  typedef struct packed {
    logic             kind;
    logic [POS_W-1:0] line;
    logic [RUN_W-1:0] len;
    logic             last;
  } hint_t;

  function automatic logic [RUN_W-1:0] bump(input logic [RUN_W-1:0] c);
    return (c < RUN_MAX) ? c + 6'd1 : RUN_MAX;
  endfunction

  function automatic logic [RUN_W-1:0] clamp_count(input logic [RUN_W-1:0] v,
                                                  input logic [RUN_W-1:0] maxv);
    logic [RUN_W-1:0] x;
    x = (v == '0) ? 6'd1 : v;
    return (x > maxv) ? maxv : x;
  endfunction

endpackage

// ===== src/rclh_front.sv =====
// front part: takes cells, keeps row/column run counters, queues hint entries
// depends on rclh_pkg

module rclh_front import rclh_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [RUN_W-1:0]  cfg_wdata,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic              cell_filled,
  input  logic              q_full,
  output logic              q_push,
  output hint_t             q_data
);

  localparam logic [1:0] S_CELL  = 2'd0;
  localparam logic [1:0] S_COL   = 2'd1;
  localparam logic [1:0] S_FLUSH = 2'd2;

  logic [1:0]       state_r;
  logic [RUN_W-1:0] num_rows_r, num_cols_r;
  logic [POS_W-1:0] row_pos_r, col_pos_r, scan_r;
  logic [RUN_W-1:0] row_run_r;
  logic [RUN_W-1:0] col_runs_r [MAX_COLS];
  hint_t            col_hold_r;
  logic             any_flush_r;

  logic [POS_W-1:0]    rd_idx;
  logic [RUN_W-1:0]    cr, cr_nxt, row_len, row_run_nxt;
  logic [MAX_COLS-1:0] nz, nz_after, colmask, above, rem;
  logic                accept, row_end, grid_end, row_emit, col_emit, any_flush, flush_hit;

  assign in_tready = (state_r == S_CELL) && !q_full;
  assign accept    = in_tvalid && in_tready;

  // one shared read port: scan index while flushing, current column otherwise
  assign rd_idx = (state_r == S_FLUSH) ? scan_r : col_pos_r;
  assign cr     = col_runs_r[rd_idx];

  always_comb begin
    for (int k = 0; k < MAX_COLS; k++) begin
      nz[k]      = (col_runs_r[k] != '0);
      colmask[k] = (RUN_W'(k) < num_cols_r);
      above[k]   = (RUN_W'(k) > {1'b0, scan_r});
    end
    nz_after            = nz;
    nz_after[col_pos_r] = cell_filled;
  end

  assign row_end  = ({1'b0, col_pos_r} + 6'd1) >= num_cols_r;
  assign grid_end = row_end && (({1'b0, row_pos_r} + 6'd1) >= num_rows_r);

  assign row_emit    = (!cell_filled && (row_run_r != '0)) || (cell_filled && row_end);
  assign row_len     = cell_filled ? bump(row_run_r) : row_run_r;
  assign col_emit    = !cell_filled && (cr != '0);
  assign cr_nxt      = cell_filled ? bump(cr) : '0;
  assign row_run_nxt = (row_end || !cell_filled) ? '0 : bump(row_run_r);
  assign any_flush   = grid_end && ((nz_after & colmask) != '0);

  assign rem       = nz & colmask & above;
  assign flush_hit = nz[scan_r] && colmask[scan_r];

  always_comb begin
    q_push = 1'b0;
    q_data = '0;
    unique case (state_r)
      S_CELL: begin
        if (accept) begin
          if (row_emit) begin
            q_push = 1'b1;
            q_data = '{kind: KIND_ROW, line: row_pos_r, len: row_len,
                       last: !col_emit && !any_flush};
          end else if (col_emit) begin
            q_push = 1'b1;
            q_data = '{kind: KIND_COL, line: col_pos_r, len: cr, last: !any_flush};
          end
        end
      end
      S_COL: begin
        q_push = !q_full;
        q_data = col_hold_r;
      end
      S_FLUSH: begin
        q_push = flush_hit && !q_full;
        q_data = '{kind: KIND_COL, line: scan_r, len: cr, last: (rem == '0)};
      end
      default: begin
        q_push = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CELL;
      num_rows_r  <= RUN_W'(MAX_ROWS);
      num_cols_r  <= RUN_W'(MAX_COLS);
      row_pos_r   <= '0;
      col_pos_r   <= '0;
      row_run_r   <= '0;
      scan_r      <= '0;
      any_flush_r <= 1'b0;
      for (int k = 0; k < MAX_COLS; k++) col_runs_r[k] <= '0;
    end else if (cfg_we) begin
      if (cfg_addr == REG_NUM_ROWS || cfg_addr == REG_NUM_COLS) begin
        if (cfg_addr == REG_NUM_ROWS) num_rows_r <= clamp_count(cfg_wdata, RUN_W'(MAX_ROWS));
        else num_cols_r <= clamp_count(cfg_wdata, RUN_W'(MAX_COLS));
        state_r   <= S_CELL;
        row_pos_r <= '0;
        col_pos_r <= '0;
        row_run_r <= '0;
        for (int k = 0; k < MAX_COLS; k++) col_runs_r[k] <= '0;
      end
    end else begin
      unique case (state_r)
        S_CELL: begin
          if (accept) begin
            row_run_r   <= row_run_nxt;
            any_flush_r <= any_flush;
            scan_r      <= '0;
            col_hold_r  <= '{kind: KIND_COL, line: col_pos_r, len: cr, last: !any_flush};
            if (grid_end) begin
              row_pos_r <= '0;
              col_pos_r <= '0;
            end else if (row_end) begin
              row_pos_r <= row_pos_r + 5'd1;
              col_pos_r <= '0;
            end else begin
              col_pos_r <= col_pos_r + 5'd1;
            end
            // grid done with nothing left to flush: start the next grid clean
            if (grid_end && !any_flush) begin
              for (int k = 0; k < MAX_COLS; k++) col_runs_r[k] <= '0;
            end else begin
              col_runs_r[col_pos_r] <= cr_nxt;
            end
            if (row_emit && col_emit) state_r <= S_COL;
            else if (any_flush) state_r <= S_FLUSH;
          end
        end
        S_COL: begin
          if (!q_full) state_r <= any_flush_r ? S_FLUSH : S_CELL;
        end
        S_FLUSH: begin
          if (!flush_hit) begin
            scan_r <= scan_r + 5'd1;
          end else if (!q_full) begin
            if (rem == '0) begin
              for (int k = 0; k < MAX_COLS; k++) col_runs_r[k] <= '0;
              state_r <= S_CELL;
            end else begin
              scan_r <= scan_r + 5'd1;
            end
          end
        end
        default: begin
          state_r <= S_CELL;
        end
      endcase
    end
  end

endmodule

// ===== src/rclh_fifo.sv =====
// short queue of hint entries between the front and back parts
// depends on rclh_pkg

module rclh_fifo import rclh_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  hint_t push_data,
  output logic  full,
  input  logic  pop,
  output logic  head_valid,
  output hint_t head_data
);

  hint_t              mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [FIFO_AW:0]   count_r;
  logic               do_push, do_pop;

  assign full       = (count_r == (FIFO_AW+1)'(FIFO_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_data  = mem_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      unique case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// ===== src/rclh_back.sv =====
// back part: drains the queue into the registered result channel
// depends on rclh_pkg

module rclh_back import rclh_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  head_valid,
  input  hint_t head_data,
  output logic  pop,
  output logic  out_tvalid,
  input  logic  out_tready,
  output hint_t out_hint
);

  logic  valid_r;
  hint_t hint_r;

  // refill the output register from the queue whenever it is empty or being taken
  assign pop        = head_valid && (!valid_r || out_tready);
  assign out_tvalid = valid_r;
  assign out_hint   = hint_r;

  always_ff @(posedge clk) begin
    if (pop) hint_r <= head_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (pop) begin
      valid_r <= 1'b1;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

endmodule

// ===== src/row_column_run_length_hints.sv =====
// a hint is queued, then registered for output; one cell per cycle while the queue
// has room; a cell giving both a row and a column run holds off input until its column hint
// is queued; the final cell of the grid starts a flush scan of open column runs (up to num_cols)
// a four-entry queue lets the cell side run ahead while results are stalled
// reset (synchronous, rst_n low): counters and column runs cleared, both sizes set to 32
module row_column_run_length_hints import rclh_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [RUN_W-1:0]  cfg_wdata,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_tdata,   // [0] cell_filled
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [15:0]       out_tdata,  // [4:0] line_index, [10:5] run_length
  output logic              out_tuser,  // [0] hint_kind
  output logic              out_tlast
);

  logic  q_push, q_full, q_pop, q_valid;
  hint_t q_in, q_head, out_hint;

  rclh_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_addr    (cfg_addr),
    .cfg_wdata   (cfg_wdata),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .cell_filled (in_tdata[0]),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_data      (q_in)
  );

  rclh_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_data  (q_in),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_data  (q_head)
  );

  rclh_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_valid),
    .head_data  (q_head),
    .pop        (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_hint   (out_hint)
  );

  assign out_tdata = {5'b0, out_hint.len, out_hint.line};
  assign out_tuser = out_hint.kind;
  assign out_tlast = out_hint.last;

endmodule

// ===== src/rclh_checker.sv =====
// port-level checks for the run length hint block, bound to the top level
// depends on assert_macros.svh
`include "assert_macros.svh"

module rclh_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic        out_tuser,
  input logic        out_tlast
);

  // the block is ready for a cell right after any reset cycle
  `RCLH_ASSERT_NXT_ALL(a_ready_after_reset, !rst_n, in_tready && !out_tvalid)

  // a finished run is never empty and the padding stays clear
  `RCLH_ASSERT_IMP(a_run_nonzero, out_tvalid, (out_tdata[10:5] != 6'd0) && (out_tdata[15:11] == 5'd0))

  `RCLH_ASSERT_NXT(a_valid_holds, out_tvalid && !out_tready, out_tvalid)

  `RCLH_ASSERT_NXT(a_payload_holds, out_tvalid && !out_tready, $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))

endmodule

bind row_column_run_length_hints rclh_checker u_rclh_checker (.*);
